### rtl/stereo_interpolating_stretcher_unit_assert.svh
// Assertion macros for the stereo interpolating stretcher.
// Expects signals clk and arst_n in the scope of each use.
`ifndef STEREO_INTERPOLATING_STRETCHER_UNIT_ASSERT_SVH
`define STEREO_INTERPOLATING_STRETCHER_UNIT_ASSERT_SVH
// Same-cycle implication.
`define SIS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define SIS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/sis_pkg.sv
// Shared types, constants and helpers of the stereo interpolating stretcher.
// No dependencies.
`default_nettype none
package sis_pkg;
	localparam int SAMPLE_W          = 16;
	localparam int FACTOR_W          = 13;
	localparam int CFG_IDX_W         = 1;
	localparam int F_MIN             = 16;
	localparam int F_MAX             = 4096;
	localparam int MAX_RESULTS       = 32;
	localparam int DEF_MAX_INPUT_LEN = 65536;
	localparam int DIV_VW            = 18;
	localparam int SUM_W             = 21;

	typedef enum logic [1:0] {
		MODE_LINEAR  = 2'd0,
		MODE_SQUARED = 2'd1,
		MODE_INVLIN  = 2'd2,
		MODE_SMOOTH  = 2'd3
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'd1;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_smp(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32767);
		lo = -SUM_W'(32768);
		if (v > hi)
			return 16'sh7fff;
		else if (v < lo)
			return 16'sh8000;
		else
			return v[SAMPLE_W-1:0];
	endfunction
endpackage
`default_nettype wire

### rtl/stereo_interpolating_stretcher_unit.sv
// Stereo interpolating stretcher: resamples a buffer of stereo samples by a Q5.8 factor
// with linear, squared, smoothstep or inverse-linear weighting. Takes one input beat at a
// time and is not ready while that beat's outputs are worked out and delivered. Each output
// runs through one shared restoring divider (DW bits wide, 45 at the default length) for
// its fraction and once more per channel in inverse-linear mode when the samples differ,
// and, outside inverse-linear mode, through one shared multiplier. Each input beat first
// passes the S_NF, S_TOT and S_CHK states before its outputs are worked out.
// Uses sis_pkg and sis_div.
`default_nettype none
`include "stereo_interpolating_stretcher_unit_assert.svh"
module stereo_interpolating_stretcher_unit #(
	parameter int MAX_INPUT_LEN = sis_pkg::DEF_MAX_INPUT_LEN
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [31:0]                    s_axis_tdata,  // in_left, in_right
	input  wire logic                           s_axis_tlast,  // in_last
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic      [31:0]                    m_axis_tdata,  // out_left, out_right
	output logic                                m_axis_tlast,  // out_end
	input  wire logic                           cfg_we,
	input  wire logic [sis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sis_pkg::FACTOR_W-1:0]   cfg_data
);
	localparam int CW  = $clog2(MAX_INPUT_LEN + 1);
	localparam int IW  = CW + 4;
	localparam int NFW = CW + 13;
	localparam int MW  = (CW + 2 > 19) ? CW + 2 : 19;
	localparam int DW  = (IW + 24 > 34) ? IW + 24 : 34;
	localparam int VW  = sis_pkg::DIV_VW;
	localparam int SW  = sis_pkg::SAMPLE_W;

	typedef enum logic [12:0] {
		S_IDLE  = 13'b0000000000001,
		S_NF    = 13'b0000000000010,
		S_TOT   = 13'b0000000000100,
		S_CHK   = 13'b0000000001000,
		S_TDIV  = 13'b0000000010000,
		S_WSEL  = 13'b0000000100000,
		S_SQ    = 13'b0000001000000,
		S_SMO   = 13'b0000010000000,
		S_BLEND = 13'b0000100000000,
		S_ADD   = 13'b0001000000000,
		S_INV   = 13'b0010000000000,
		S_IDIV  = 13'b0100000000000,
		S_OUT   = 13'b1000000000000
	} state_t;

	state_t                      state_q;
	logic [sis_pkg::FACTOR_W-1:0] fac_q;
	sis_pkg::mode_t              mode_q;
	logic [CW-1:0]               n_q;
	logic [IW-1:0]               idx_q;
	logic                        have_prev_q;
	logic signed [SW-1:0]        prev_l_q, prev_r_q, x_l_q, x_r_q;
	logic signed [SW-1:0]        pa_l_q, pa_r_q, pb_l_q, pb_r_q;
	logic signed [SW-1:0]        res_l_q, res_r_q;
	logic [sis_pkg::FACTOR_W-1:0] f_q;
	logic                        last_q;
	logic [NFW-1:0]              nf_q;
	logic [IW-1:0]               tot_q;
	logic [5:0]                  cnt_q;
	logic [15:0]                 t_q;
	logic [17:0]                 w_q;
	logic signed [19:0]          bl_q;
	logic                        ch_q;
	logic                        end_q;

	logic signed [MW-1:0]        op_a, op_b;
	logic signed [2*MW-1:0]      prod_c;
	logic signed [SW-1:0]        a_c, b_c, y_c;
	logic signed [SW:0]          d_c;
	logic signed [18:0]          num_c, den_c;
	logic [17:0]                 num_mag, den_mag;
	logic                        neg_c;
	logic                        div_go;
	logic [DW-1:0]               div_dvd;
	logic [VW-1:0]               div_dvs;
	logic [DW-1:0]               quo;
	sis_pkg::div_stat_t          div_st;
	logic                        in_acc, last_c, emit_a, emit_b;
	logic [sis_pkg::FACTOR_W-1:0] f_clamp;
	logic [CW:0]                 n_inc;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {res_r_q, res_l_q};
	assign m_axis_tlast  = end_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign n_inc         = {1'b0, n_q} + 1'b1;
	assign last_c        = s_axis_tlast || (n_inc >= (CW+1)'(MAX_INPUT_LEN));

	always_comb begin
		if (fac_q < sis_pkg::FACTOR_W'(sis_pkg::F_MIN))
			f_clamp = sis_pkg::FACTOR_W'(sis_pkg::F_MIN);
		else if (fac_q > sis_pkg::FACTOR_W'(sis_pkg::F_MAX))
			f_clamp = sis_pkg::FACTOR_W'(sis_pkg::F_MAX);
		else
			f_clamp = fac_q;
	end

	assign emit_a = have_prev_q && (n_q != '0) && (cnt_q < 6'(sis_pkg::MAX_RESULTS)) &&
		(NFW'({idx_q, 8'd0}) < nf_q) && (!last_q || (idx_q < tot_q));
	assign emit_b = last_q && (cnt_q < 6'(sis_pkg::MAX_RESULTS)) && (idx_q < tot_q);

	assign a_c     = ch_q ? pa_r_q : pa_l_q;
	assign b_c     = ch_q ? pb_r_q : pb_l_q;
	assign d_c     = {b_c[SW-1], b_c} - {a_c[SW-1], a_c};
	assign num_c   = $signed({3'b000, t_q}) - $signed({{2{a_c[SW-1]}}, a_c, 1'b0});
	assign den_c   = $signed({{2{b_c[SW-1]}}, b_c, 1'b0}) - $signed({{2{a_c[SW-1]}}, a_c, 1'b0});
	assign num_mag = num_c[18] ? 18'(-num_c) : 18'(num_c);
	assign den_mag = den_c[18] ? 18'(-den_c) : 18'(den_c);
	assign neg_c   = num_c[18] ^ den_c[18];

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_NF: begin
				op_a = MW'(n_q);
				op_b = MW'(f_q);
			end
			S_TOT: begin
				op_a = MW'(n_inc);
				op_b = MW'(f_q);
			end
			S_SQ: begin
				op_a = MW'(t_q);
				op_b = MW'(t_q);
			end
			S_SMO: begin
				op_a = MW'(w_q);
				op_b = MW'(18'd196608 - {1'b0, t_q, 1'b0});
			end
			S_BLEND: begin
				op_a = MW'(d_c);
				op_b = MW'(w_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end
	assign prod_c = op_a * op_b;

	always_comb begin
		div_go  = 1'b0;
		div_dvd = DW'({idx_q, 24'd0});
		div_dvs = VW'(f_q);
		if (state_q == S_CHK && (emit_a || emit_b))
			div_go = 1'b1;
		if (state_q == S_INV && den_c != '0) begin
			div_go  = 1'b1;
			div_dvd = DW'({num_mag, 15'd0});
			div_dvs = den_mag;
		end
	end

	always_comb begin
		y_c = '0;
		if (state_q == S_ADD) begin
			y_c = sis_pkg::sat_smp(sis_pkg::SUM_W'(a_c) + sis_pkg::SUM_W'(bl_q));
		end else if (state_q == S_INV) begin
			if (num_c[18])
				y_c = 16'sh8000;
			else if (num_c != '0)
				y_c = 16'sh7fff;
		end else if (neg_c) begin
			y_c = (quo > DW'(32768)) ? 16'sh8000 : SW'(-quo[SW-1:0]);
		end else begin
			y_c = (quo > DW'(32767)) ? 16'sh7fff : quo[SW-1:0];
		end
	end

	sis_div #(.DW(DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (quo),
		.stat     (div_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fac_q       <= sis_pkg::FACTOR_W'(256);
			mode_q      <= sis_pkg::MODE_LINEAR;
			n_q         <= '0;
			idx_q       <= '0;
			have_prev_q <= 1'b0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			cnt_q       <= '0;
			ch_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sis_pkg::REG_FACTOR: fac_q  <= cfg_data;
					sis_pkg::REG_MODE:   mode_q <= sis_pkg::mode_t'(cfg_data[1:0]);
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q   <= '0;
						state_q <= S_NF;
					end
				end
				S_NF:  state_q <= S_TOT;
				S_TOT: state_q <= S_CHK;
				S_CHK: begin
					ch_q <= 1'b0;
					if (emit_a || emit_b) begin
						state_q <= S_TDIV;
					end else begin
						state_q <= S_IDLE;
						if (last_q) begin
							prev_l_q    <= '0;
							prev_r_q    <= '0;
							have_prev_q <= 1'b0;
							n_q         <= '0;
							idx_q       <= '0;
						end else begin
							prev_l_q    <= x_l_q;
							prev_r_q    <= x_r_q;
							have_prev_q <= 1'b1;
							n_q         <= CW'(n_inc);
						end
					end
				end
				S_TDIV: if (div_st.done) state_q <= S_WSEL;
				S_WSEL: begin
					unique case (mode_q)
						sis_pkg::MODE_LINEAR: state_q <= S_BLEND;
						sis_pkg::MODE_INVLIN: state_q <= S_INV;
						default:              state_q <= S_SQ;
					endcase
				end
				S_SQ:    state_q <= (mode_q == sis_pkg::MODE_SMOOTH) ? S_SMO : S_BLEND;
				S_SMO:   state_q <= S_BLEND;
				S_BLEND: state_q <= S_ADD;
				S_ADD, S_INV, S_IDIV: begin
					if (state_q != S_INV || den_c == '0) begin
						if (state_q != S_IDIV || div_st.done) begin
							ch_q    <= 1'b1;
							state_q <= ch_q ? S_OUT : S_WSEL;
						end
					end else begin
						state_q <= S_IDIV;
					end
				end
				S_OUT: begin
					if (m_axis_tready) begin
						idx_q   <= idx_q + 1'b1;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_CHK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_l_q  <= s_axis_tdata[15:0];
			x_r_q  <= s_axis_tdata[31:16];
			last_q <= last_c;
			f_q    <= f_clamp;
		end
		if (state_q == S_NF)
			nf_q <= NFW'(prod_c);
		if (state_q == S_TOT)
			tot_q <= IW'(prod_c >>> 8);
		if (state_q == S_CHK) begin
			end_q <= last_q && (({1'b0, idx_q} + 1'b1) == {1'b0, tot_q});
			if (emit_a) begin
				pa_l_q <= prev_l_q;
				pa_r_q <= prev_r_q;
				pb_l_q <= x_l_q;
				pb_r_q <= x_r_q;
			end else begin
				pa_l_q <= x_l_q;
				pa_r_q <= x_r_q;
				pb_l_q <= '0;
				pb_r_q <= '0;
			end
		end
		if (state_q == S_TDIV && div_st.done)
			t_q <= quo[15:0];
		if (state_q == S_WSEL)
			w_q <= {2'b00, t_q};
		if (state_q == S_SQ || state_q == S_SMO)
			w_q <= 18'(prod_c >>> 16);
		if (state_q == S_BLEND)
			bl_q <= 20'(prod_c >>> 16);
		if (state_q == S_ADD || (state_q == S_INV && den_c == '0) ||
		    (state_q == S_IDIV && div_st.done)) begin
			if (ch_q)
				res_r_q <= y_c;
			else
				res_l_q <= y_c;
		end
	end

	`SIS_ASSERT_IMP(a_no_overlap, s_axis_tready, !m_axis_tvalid, "input and output open together")
	`SIS_ASSERT_NXT(a_out_to_chk, m_axis_tvalid && m_axis_tready, state_q == S_CHK, "no check after output beat")
	`SIS_ASSERT_IMP(a_cnt_limit, m_axis_tvalid, cnt_q < 6'(sis_pkg::MAX_RESULTS), "too many output beats")
	`SIS_ASSERT_IMP(a_div_free, div_go, !div_st.busy, "divider started while busy")
endmodule
`default_nettype wire

### rtl/sis_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sis_pkg for the status struct.
`default_nettype none
module sis_div #(
	parameter int DW = 45,
	parameter int VW = 18
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DW-1:0]         dividend,
	input  wire logic [VW-1:0]         divisor,
	output logic      [DW-1:0]         quotient,
	output sis_pkg::div_stat_t         stat
);
	localparam int CNT_W = $clog2(DW + 1);

	logic [DW-1:0]    dvd_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
			dvd_q <= {dvd_q[DW-2:0], fits};
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule
`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for stereo_interpolating_stretcher_unit: drives stereo sample
// beats and register writes, predicts every interpolated output beat and compares them.
// Depends on sis_pkg and the stereo_interpolating_stretcher_unit RTL.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               fin;
	} stereo_out_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_we;
	logic [sis_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [sis_pkg::FACTOR_W-1:0] cfg_data;

	stereo_out_t expected_outputs[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	logic [sis_pkg::FACTOR_W-1:0] factor_reg = 13'd256;
	sis_pkg::mode_t mode_reg = sis_pkg::MODE_LINEAR;
	longint held_left = 0;
	longint held_right = 0;
	bit held_valid = 0;
	longint samples_taken = 0;
	longint next_out = 0;

	stereo_interpolating_stretcher_unit uut (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint clip16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint shape_sample(longint a, longint b, longint t);
		longint w;
		longint num;
		longint den;
		case (mode_reg)
			sis_pkg::MODE_LINEAR: begin
				return clip16(a + (((b - a) * t) >>> 16));
			end
			sis_pkg::MODE_SQUARED: begin
				w = (t * t) >> 16;
				return clip16(a + (((b - a) * w) >>> 16));
			end
			sis_pkg::MODE_INVLIN: begin
				num = t - 2 * a;
				den = 2 * b - 2 * a;
				if (den == 0)
					return (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
				return clip16((num * 32768) / den);
			end
			default: begin
				w = (t * t) >> 16;
				w = (w * (3 * 65536 - 2 * t)) >> 16;
				return clip16(a + (((b - a) * w) >>> 16));
			end
		endcase
	endfunction

	function automatic void push_output(longint al, longint ar, longint bl, longint br,
			longint idx, longint f, bit fin);
		stereo_out_t o;
		longint t;
		t = (((idx * 256) % f) << 16) / f;
		o.left = 16'(shape_sample(al, bl, t));
		o.right = 16'(shape_sample(ar, br, t));
		o.fin = fin;
		expected_outputs.push_back(o);
	endfunction

	function automatic void resample_beat(longint l, longint r, bit lst);
		longint f;
		longint n;
		longint idx;
		longint total;
		bit ends;
		int cnt;
		f = factor_reg;
		n = samples_taken;
		idx = next_out;
		total = 0;
		cnt = 0;
		if (f < sis_pkg::F_MIN)
			f = sis_pkg::F_MIN;
		if (f > sis_pkg::F_MAX)
			f = sis_pkg::F_MAX;
		ends = lst || (n + 1 >= sis_pkg::DEF_MAX_INPUT_LEN);
		if (ends)
			total = ((n + 1) * f) >> 8;
		if (held_valid && n >= 1) begin
			while (cnt < sis_pkg::MAX_RESULTS && (idx * 256) / f <= n - 1 &&
			       (!ends || idx < total)) begin
				push_output(held_left, held_right, l, r, idx, f, ends && idx + 1 == total);
				cnt++;
				idx++;
			end
		end
		if (ends) begin
			while (cnt < sis_pkg::MAX_RESULTS && idx < total) begin
				push_output(l, r, 0, 0, idx, f, idx + 1 == total);
				cnt++;
				idx++;
			end
			held_left = 0;
			held_right = 0;
			held_valid = 0;
			samples_taken = 0;
			next_out = 0;
		end else begin
			held_left = l;
			held_right = r;
			held_valid = 1;
			samples_taken = n + 1;
			next_out = idx;
		end
	endfunction

	task automatic send_sample(logic signed [15:0] l, logic signed [15:0] r, logic lst);
		if ($urandom_range(99) < send_idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		s_axis_tdata = {r, l};
		s_axis_tlast = lst;
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		resample_beat(l, r, lst);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic write_reg(logic [sis_pkg::CFG_IDX_W-1:0] idx,
			logic [sis_pkg::FACTOR_W-1:0] val);
		wait (expected_outputs.size() == 0);
		repeat (400) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == sis_pkg::REG_FACTOR)
			factor_reg = val;
		else
			mode_reg = sis_pkg::mode_t'(val[1:0]);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_extremes();
		write_reg(sis_pkg::REG_MODE, sis_pkg::MODE_LINEAR);
		write_reg(sis_pkg::REG_FACTOR, 13'd256);
		send_sample(16'sh7fff, 16'sh8000, 1'b0);
		send_sample(16'sh8000, 16'sh7fff, 1'b0);
		send_sample(16'sh0000, 16'shffff, 1'b0);
		send_sample(16'shffff, 16'sh0001, 1'b1);
		send_sample(16'sh1234, 16'shedcb, 1'b1);
	endtask

	task automatic test_modes();
		sis_pkg::mode_t m;
		write_reg(sis_pkg::REG_FACTOR, 13'd800);
		for (int k = 0; k < 4; k++) begin
			m = sis_pkg::mode_t'(k);
			write_reg(sis_pkg::REG_MODE, m);
			send_sample(16'sh8000, 16'sh7fff, 1'b0);
			send_sample(16'sh7fff, 16'sh8000, 1'b0);
			send_sample(16'sh0100, 16'sh0100, 1'b1);
		end
	endtask

	task automatic test_clamping();
		write_reg(sis_pkg::REG_MODE, sis_pkg::MODE_INVLIN);
		write_reg(sis_pkg::REG_FACTOR, 13'd0);
		for (int k = 0; k < 4; k++)
			send_sample(16'sh0000, 16'sh0000, k == 3);
		write_reg(sis_pkg::REG_FACTOR, 13'h1fff);
		send_sample(16'sh0000, 16'sh0000, 1'b0);
		send_sample(16'sh0000, 16'sh0000, 1'b0);
		send_sample(-16'sh0004, 16'sh0004, 1'b1);
	endtask

	task automatic test_factor_change();
		write_reg(sis_pkg::REG_MODE, sis_pkg::MODE_SMOOTH);
		write_reg(sis_pkg::REG_FACTOR, 13'd16);
		send_sample(16'sh4000, 16'shc000, 1'b0);
		send_sample(16'sh2000, 16'she000, 1'b0);
		send_sample(16'sh1000, 16'shf000, 1'b0);
		write_reg(sis_pkg::REG_FACTOR, 13'd4096);
		send_sample(16'sh7000, 16'sh9000, 1'b0);
		write_reg(sis_pkg::REG_FACTOR, 13'd4000);
		send_sample(16'sh0000, 16'sh7fff, 1'b1);
	endtask

	task automatic test_random_buffers();
		int sent;
		int len;
		int phase;
		sent = 0;
		phase = 0;
		while (sent < 80) begin
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 83; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 83; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			phase++;
			write_reg(sis_pkg::REG_MODE, sis_pkg::mode_t'($urandom_range(3)));
			write_reg(sis_pkg::REG_FACTOR, ($urandom_range(3) == 0) ? 13'($urandom)
				: 13'($urandom_range(64, 700)));
			len = $urandom_range(1, 10);
			for (int k = 0; k < len; k++)
				send_sample(rand_sample(), rand_sample(),
					(k == len - 1) || ($urandom_range(19) == 0));
			sent += len;
		end
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		stereo_out_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_outputs.size() == 0) begin
				$error("unexpected output beat %h", m_axis_tdata);
				errors++;
			end else begin
				e = expected_outputs.pop_front();
				if (m_axis_tdata[15:0] !== e.left) begin
					$error("out_left expected %0d got %0d", e.left, $signed(m_axis_tdata[15:0]));
					errors++;
				end
				if (m_axis_tdata[31:16] !== e.right) begin
					$error("out_right expected %0d got %0d", e.right,
						$signed(m_axis_tdata[31:16]));
					errors++;
				end
				if (m_axis_tlast !== e.fin) begin
					$error("out_end expected %0d got %0d", e.fin, m_axis_tlast);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 40000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_modes();
		test_clamping();
		test_factor_change();
		test_random_buffers();
		wait (expected_outputs.size() == 0);
		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/sis_pkg.sv
rtl/sis_div.sv
rtl/stereo_interpolating_stretcher_unit.sv
tb/sv/tb.sv
